// ===== design/svgps_pkg.sv =====
// Shared types, character codes and tag tables of the SVG path attribute scanner.
package svgps_pkg;

    localparam int FRAC_DIGITS_DEFAULT = 3;

    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 3;
    localparam int VKIND_W  = 2;
    localparam int WIDTH_W  = 26;
    localparam int POW_W    = 20;

    localparam logic [WIDTH_W-1:0] ACC_MAX = {WIDTH_W{1'b1}};

    localparam logic [3:0] TAG_STROKE_LEN = 4'd13;
    localparam logic [2:0] TAG_FILL_LEN   = 3'd5;
    localparam logic [2:0] TAG_ID_LEN     = 3'd4;
    localparam logic [1:0] TAG_PATH_LEN   = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        MODE_MATCH = 3'd0,
        MODE_WIDTH = 3'd1,
        MODE_FILL  = 3'd2,
        MODE_ID    = 3'd3,
        MODE_PATH  = 3'd4
    } t_scan_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_FILL_CHAR   = 3'd0,
        KIND_ID_CHAR     = 3'd1,
        KIND_PATH_CHAR   = 3'd2,
        KIND_VALUE_END   = 3'd3,
        KIND_ELEMENT_END = 3'd4
    } t_kind;

    typedef enum logic [VKIND_W-1:0] {
        VKIND_WIDTH = 2'd0,
        VKIND_FILL  = 2'd1,
        VKIND_ID    = 2'd2,
        VKIND_PATH  = 2'd3
    } t_value_kind;

    function automatic logic [CHAR_W-1:0] tag_stroke_char(input logic [3:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            4'd0:    ch = "s";
            4'd1:    ch = "t";
            4'd2:    ch = "r";
            4'd3:    ch = "o";
            4'd4:    ch = "k";
            4'd5:    ch = "e";
            4'd6:    ch = "-";
            4'd7:    ch = "w";
            4'd8:    ch = "i";
            4'd9:    ch = "d";
            4'd10:   ch = "t";
            4'd11:   ch = "h";
            4'd12:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] tag_fill_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = "f";
            3'd1:    ch = "i";
            3'd2:    ch = "l";
            3'd3:    ch = "l";
            3'd4:    ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] tag_id_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = "i";
            3'd1:    ch = "d";
            3'd2:    ch = "=";
            3'd3:    ch = CHAR_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] tag_path_char(input logic [1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            2'd0:    ch = "d";
            2'd1:    ch = "=";
            2'd2:    ch = CHAR_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [POW_W-1:0] pow_ten(input logic [2:0] idx);
        logic [POW_W-1:0] p;
        case (idx)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== design/svgps_stream_if.sv =====
// Valid/ready channel interfaces for the scanner's character input and result output.
interface svgps_char_if;
    import svgps_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface svgps_result_if;
    import svgps_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_out;
    logic [VKIND_W-1:0] value_kind;
    logic [WIDTH_W-1:0] stroke_width;

    modport source (output valid, output kind, output char_out, output value_kind,
                    output stroke_width, input ready);
    modport sink   (input valid, input kind, input char_out, input value_kind,
                    input stroke_width, output ready);
endinterface

// ===== design/svg_path_attribute_scanner_core.sv =====
// Top level of the SVG path attribute scanner: tag matching, value streaming, width accumulation.
// The scanner takes one byte of element text per clock and answers with at most one result beat
// in the next cycle, from a single output register; a new byte is accepted in every cycle that the
// output register is empty or being drained, so throughput is one byte per clock, set by the
// update of the mode, matcher counts and width accumulator from each byte (a times-ten shift-add and
// a 4 by 20 bit digit product). Stroke width is reported on element end, scaled by
// ten to the FRAC_DIGITS, saturating at the 26-bit maximum.
module svg_path_attribute_scanner_core #(
    parameter int FRAC_DIGITS = svgps_pkg::FRAC_DIGITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    svgps_char_if.sink        i_char,
    svgps_result_if.source    o_result
);
    import svgps_pkg::*;

    localparam logic [2:0] FRAC_SEL = 3'(FRAC_DIGITS);
    localparam int         SUM_W    = WIDTH_W + 5;

    t_scan_mode          r_mode,  n_mode;
    logic [3:0]          r_width_cnt, n_width_cnt;
    logic [2:0]          r_fill_cnt,  n_fill_cnt;
    logic [2:0]          r_id_cnt,    n_id_cnt;
    logic [1:0]          r_path_cnt,  n_path_cnt;
    logic                r_dot_seen,  n_dot_seen;
    logic [2:0]          r_frac_pos,  n_frac_pos;
    logic [WIDTH_W-1:0]  r_accum,     n_accum;

    logic                r_out_valid, n_out_valid;
    t_kind               r_kind,      n_kind;
    logic [CHAR_W-1:0]   r_char_out,  n_char_out;
    t_value_kind         r_vkind,     n_vkind;
    logic [WIDTH_W-1:0]  r_stroke,    n_stroke;

    logic                accept;
    logic [CHAR_W-1:0]   ch;
    logic                is_digit;
    logic [3:0]          digit;
    logic [2:0]          frac_inc;
    logic [2:0]          pow_sel;
    logic [POW_W+3:0]    digit_term;
    logic [SUM_W-1:0]    accum_ext;
    logic [SUM_W-1:0]    sum_int;
    logic [SUM_W-1:0]    sum_frac;
    logic [SUM_W-1:0]    sum_sel;
    logic [3:0]          adv_width;
    logic [2:0]          adv_fill;
    logic [2:0]          adv_id;
    logic [1:0]          adv_path;

    assign i_char.ready          = !r_out_valid || o_result.ready;
    assign accept                = i_char.valid && i_char.ready;
    assign ch                    = i_char.char_in;

    assign o_result.valid        = r_out_valid;
    assign o_result.kind         = r_kind;
    assign o_result.char_out     = r_char_out;
    assign o_result.value_kind   = r_vkind;
    assign o_result.stroke_width = r_stroke;

    // width digit arithmetic
    assign is_digit   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign digit      = 4'(ch - CHAR_ZERO);
    assign frac_inc   = (r_frac_pos != 3'd7) ? r_frac_pos + 3'd1 : r_frac_pos;
    assign pow_sel    = r_dot_seen ? (FRAC_SEL - frac_inc) : FRAC_SEL;
    assign digit_term = (POW_W+4)'(digit) * (POW_W+4)'(pow_ten(pow_sel));
    assign accum_ext  = SUM_W'(r_accum);
    assign sum_int    = (accum_ext << 3) + (accum_ext << 1) + SUM_W'(digit_term);
    assign sum_frac   = (frac_inc <= FRAC_SEL) ? accum_ext + SUM_W'(digit_term) : accum_ext;
    assign sum_sel    = r_dot_seen ? sum_frac : sum_int;

    // naive prefix matchers
    assign adv_width = (r_width_cnt < TAG_STROKE_LEN && tag_stroke_char(r_width_cnt) == ch)
                       ? r_width_cnt + 4'd1 : 4'd0;
    assign adv_fill  = (r_fill_cnt < TAG_FILL_LEN && tag_fill_char(r_fill_cnt) == ch)
                       ? r_fill_cnt + 3'd1 : 3'd0;
    assign adv_id    = (r_id_cnt < TAG_ID_LEN && tag_id_char(r_id_cnt) == ch)
                       ? r_id_cnt + 3'd1 : 3'd0;
    assign adv_path  = (r_path_cnt < TAG_PATH_LEN && tag_path_char(r_path_cnt) == ch)
                       ? r_path_cnt + 2'd1 : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MATCH;
            r_width_cnt <= '0;
            r_fill_cnt  <= '0;
            r_id_cnt    <= '0;
            r_path_cnt  <= '0;
            r_dot_seen  <= 1'b0;
            r_frac_pos  <= '0;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_width_cnt <= n_width_cnt;
            r_fill_cnt  <= n_fill_cnt;
            r_id_cnt    <= n_id_cnt;
            r_path_cnt  <= n_path_cnt;
            r_dot_seen  <= n_dot_seen;
            r_frac_pos  <= n_frac_pos;
            r_accum     <= n_accum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_char_out <= n_char_out;
        r_vkind    <= n_vkind;
        r_stroke   <= n_stroke;
    end

    always_comb begin
        n_mode      = r_mode;
        n_width_cnt = r_width_cnt;
        n_fill_cnt  = r_fill_cnt;
        n_id_cnt    = r_id_cnt;
        n_path_cnt  = r_path_cnt;
        n_dot_seen  = r_dot_seen;
        n_frac_pos  = r_frac_pos;
        n_accum     = r_accum;
        n_out_valid = r_out_valid && !o_result.ready;
        n_kind      = r_kind;
        n_char_out  = r_char_out;
        n_vkind     = r_vkind;
        n_stroke    = r_stroke;

        if (accept) begin
            n_out_valid = 1'b0;
            n_kind      = KIND_FILL_CHAR;
            n_char_out  = '0;
            n_vkind     = VKIND_WIDTH;
            n_stroke    = '0;
            case (r_mode)
                MODE_WIDTH: begin
                    if (ch == CHAR_SEMI || ch == CHAR_QUOTE) begin
                        n_mode      = MODE_MATCH;
                        n_dot_seen  = 1'b0;
                        n_frac_pos  = '0;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_VALUE_END;
                        n_vkind     = VKIND_WIDTH;
                    end else if (ch == CHAR_DOT) begin
                        n_dot_seen = 1'b1;
                    end else if (is_digit) begin
                        if (r_dot_seen) begin
                            n_frac_pos = frac_inc;
                        end
                        n_accum = (sum_sel > SUM_W'(ACC_MAX)) ? ACC_MAX : sum_sel[WIDTH_W-1:0];
                    end
                end
                MODE_FILL: begin
                    n_out_valid = 1'b1;
                    if (ch == CHAR_SEMI || ch == CHAR_QUOTE) begin
                        n_mode     = MODE_MATCH;
                        n_dot_seen = 1'b0;
                        n_frac_pos = '0;
                        n_kind     = KIND_VALUE_END;
                        n_vkind    = VKIND_FILL;
                    end else begin
                        n_kind     = KIND_FILL_CHAR;
                        n_char_out = ch;
                    end
                end
                MODE_ID, MODE_PATH: begin
                    n_out_valid = 1'b1;
                    if (ch == CHAR_QUOTE) begin
                        n_mode     = MODE_MATCH;
                        n_dot_seen = 1'b0;
                        n_frac_pos = '0;
                        n_kind     = KIND_VALUE_END;
                        n_vkind    = (r_mode == MODE_ID) ? VKIND_ID : VKIND_PATH;
                    end else begin
                        n_kind     = (r_mode == MODE_ID) ? KIND_ID_CHAR : KIND_PATH_CHAR;
                        n_char_out = ch;
                    end
                end
                default: begin
                    if (ch == CHAR_GT) begin
                        n_mode      = MODE_MATCH;
                        n_width_cnt = '0;
                        n_fill_cnt  = '0;
                        n_id_cnt    = '0;
                        n_path_cnt  = '0;
                        n_dot_seen  = 1'b0;
                        n_frac_pos  = '0;
                        n_accum     = '0;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_ELEMENT_END;
                        n_stroke    = r_accum;
                    end else begin
                        n_mode      = MODE_MATCH;
                        n_width_cnt = adv_width;
                        n_fill_cnt  = adv_fill;
                        n_id_cnt    = adv_id;
                        n_path_cnt  = adv_path;
                        if (adv_width == TAG_STROKE_LEN) begin
                            n_mode     = MODE_WIDTH;
                            n_dot_seen = 1'b0;
                            n_frac_pos = '0;
                        end else if (adv_fill == TAG_FILL_LEN) begin
                            n_mode = MODE_FILL;
                        end else if (adv_id == TAG_ID_LEN) begin
                            n_mode = MODE_ID;
                        end else if (adv_path == TAG_PATH_LEN) begin
                            n_mode = MODE_PATH;
                        end
                        if (n_mode != MODE_MATCH) begin
                            n_width_cnt = '0;
                            n_fill_cnt  = '0;
                            n_id_cnt    = '0;
                            n_path_cnt  = '0;
                        end
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_element_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_mode == MODE_MATCH && ch == CHAR_GT
        |=> r_out_valid && r_kind == KIND_ELEMENT_END && r_accum == '0 && r_mode == MODE_MATCH)
        else $error("element end did not clear state");

    a_width_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_mode == MODE_WIDTH && ch != CHAR_SEMI && ch != CHAR_QUOTE
        |=> !r_out_valid)
        else $error("width value byte produced a result");

    a_counts_idle_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_MATCH
        |-> r_width_cnt == '0 && r_fill_cnt == '0 && r_id_cnt == '0 && r_path_cnt == '0)
        else $error("matcher count left over in value mode");

    a_dot_only_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot_seen |-> r_mode == MODE_WIDTH)
        else $error("dot flag set outside width value");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for svg_path_attribute_scanner_core: directed and random element text.
`timescale 1ns / 100ps

module tb;
    import svgps_pkg::*;

    localparam int FRAC           = FRAC_DIGITS_DEFAULT;
    localparam int STROKE_LEN     = 13;
    localparam int FILL_LEN       = 5;
    localparam int ID_LEN         = 4;
    localparam int PATH_LEN       = 3;
    localparam int RANDOM_CHARS   = 1680;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [103:0] STROKE_TAG = "stroke-width:";
    localparam logic [103:0] FILL_TAG   = "fill:";
    localparam logic [103:0] ID_TAG     = "id=\"";
    localparam logic [103:0] PATH_TAG   = "d=\"";

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  char_out;
        t_value_kind        value_kind;
        logic [WIDTH_W-1:0] stroke_width;
    } attr_token_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    svgps_char_if   char_bus ();
    svgps_result_if result_bus ();

    svg_path_attribute_scanner_core #(
        .FRAC_DIGITS(FRAC)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_bus),
        .o_result (result_bus)
    );

    attr_token_t awaited_tokens[$];
    int          error_count    = 0;
    int          chars_sent     = 0;
    int          idle_cycles    = 0;
    bit          source_steady  = 1'b0;
    bit          sink_steady    = 1'b0;
    bit          hold_requested = 1'b0;

    t_scan_mode         mode;
    logic [3:0]         stroke_hits;
    logic [2:0]         fill_hits;
    logic [2:0]         id_hits;
    logic [1:0]         d_hits;
    logic               have_dot;
    logic [2:0]         frac_count;
    logic [WIDTH_W-1:0] width_acc;

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] tag_char(input logic [103:0] tag, input int len,
                                            input int idx);
        return tag[8*(len-1-idx) +: 8];
    endfunction

    function automatic int next_hits(input int hits, input logic [103:0] tag, input int len,
                                     input logic [7:0] c);
        if (hits < len && tag_char(tag, len, hits) == c)
            return hits + 1;
        return 0;
    endfunction

    function automatic logic [63:0] ten_to(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
            p = p * 10;
        return p;
    endfunction

    function automatic void clear_hits();
        stroke_hits = '0;
        fill_hits   = '0;
        id_hits     = '0;
        d_hits      = '0;
    endfunction

    function automatic void reset_scan();
        mode       = MODE_MATCH;
        clear_hits();
        have_dot   = 1'b0;
        frac_count = '0;
        width_acc  = '0;
    endfunction

    function automatic void close_value();
        mode       = MODE_MATCH;
        have_dot   = 1'b0;
        frac_count = '0;
    endfunction

    function automatic bit scan_char(input logic [7:0] c, output attr_token_t tok);
        logic [63:0] acc;
        logic [63:0] digit;
        bit          emitted;
        tok     = '0;
        emitted = 1'b0;
        case (mode)
            MODE_WIDTH: begin
                if (c == CHAR_SEMI || c == CHAR_QUOTE) begin
                    close_value();
                    tok.kind       = KIND_VALUE_END;
                    tok.value_kind = VKIND_WIDTH;
                    emitted        = 1'b1;
                end else if (c == CHAR_DOT) begin
                    have_dot = 1'b1;
                end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    digit = 64'(c - CHAR_ZERO);
                    acc   = 64'(width_acc);
                    if (have_dot) begin
                        if (frac_count < 7)
                            frac_count = frac_count + 3'd1;
                        if (frac_count <= FRAC)
                            acc = acc + digit * ten_to(FRAC - frac_count);
                    end else begin
                        acc = acc * 10 + digit * ten_to(FRAC);
                    end
                    width_acc = (acc > ACC_MAX) ? ACC_MAX : acc[WIDTH_W-1:0];
                end
            end
            MODE_FILL: begin
                emitted = 1'b1;
                if (c == CHAR_SEMI || c == CHAR_QUOTE) begin
                    close_value();
                    tok.kind       = KIND_VALUE_END;
                    tok.value_kind = VKIND_FILL;
                end else begin
                    tok.kind     = KIND_FILL_CHAR;
                    tok.char_out = c;
                end
            end
            MODE_ID, MODE_PATH: begin
                emitted = 1'b1;
                if (c == CHAR_QUOTE) begin
                    tok.kind       = KIND_VALUE_END;
                    tok.value_kind = (mode == MODE_ID) ? VKIND_ID : VKIND_PATH;
                    close_value();
                end else begin
                    tok.kind     = (mode == MODE_ID) ? KIND_ID_CHAR : KIND_PATH_CHAR;
                    tok.char_out = c;
                end
            end
            default: begin
                if (c == CHAR_GT) begin
                    tok.kind         = KIND_ELEMENT_END;
                    tok.stroke_width = width_acc;
                    emitted          = 1'b1;
                    reset_scan();
                end else begin
                    mode        = MODE_MATCH;
                    stroke_hits = 4'(next_hits(stroke_hits, STROKE_TAG, STROKE_LEN, c));
                    fill_hits   = 3'(next_hits(fill_hits, FILL_TAG, FILL_LEN, c));
                    id_hits     = 3'(next_hits(id_hits, ID_TAG, ID_LEN, c));
                    d_hits      = 2'(next_hits(d_hits, PATH_TAG, PATH_LEN, c));
                    if (stroke_hits == STROKE_LEN) begin
                        mode       = MODE_WIDTH;
                        have_dot   = 1'b0;
                        frac_count = '0;
                        clear_hits();
                    end else if (fill_hits == FILL_LEN) begin
                        mode = MODE_FILL;
                        clear_hits();
                    end else if (id_hits == ID_LEN) begin
                        mode = MODE_ID;
                        clear_hits();
                    end else if (d_hits == PATH_LEN) begin
                        mode = MODE_PATH;
                        clear_hits();
                    end
                end
            end
        endcase
        return emitted;
    endfunction

    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] value_byte(input bit semi_ends);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_QUOTE || (semi_ends && b == CHAR_SEMI))
            b = b ^ 8'h40;
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : token_check
        attr_token_t want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (awaited_tokens.size() == 0) begin
                $error("kind: expected no beat, got %0d", result_bus.kind);
                error_count++;
            end else begin
                want = awaited_tokens.pop_front();
                check_field("kind", want.kind, result_bus.kind);
                check_field("char_out", want.char_out, result_bus.char_out);
                check_field("value_kind", want.value_kind, result_bus.value_kind);
                check_field("stroke_width", want.stroke_width, result_bus.stroke_width);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (char_bus.valid && char_bus.ready)
                     || (result_bus.valid && result_bus.ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("svg_path_attribute_scanner_core regression: fail");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin : result_sink
        int stall;
        result_bus.ready = 1'b0;
        forever begin
            if (hold_requested) begin
                hold_requested = 1'b0;
                stall          = LONG_HOLD;
            end else begin
                stall = sink_steady ? 0 : draw_gap();
            end
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int          gap;
        attr_token_t tok;
        gap = source_steady ? 0 : draw_gap();
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.char_in <= c;
        @(posedge i_clk);
        while (!char_bus.ready)
            @(posedge i_clk);
        chars_sent++;
        if (scan_char(c, tok))
            awaited_tokens.push_back(tok);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_tag(input logic [103:0] tag, input int len, input int cut);
        for (int i = 0; i < cut; i++)
            send_char(tag_char(tag, len, i));
    endtask

    task automatic wait_drained();
        char_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_element_end();
        send_char(CHAR_GT);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CHAR_GT);
    endtask

    task automatic test_fill_value();
        send_tag(FILL_TAG, FILL_LEN, FILL_LEN);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(CHAR_GT);
        send_char(CHAR_SEMI);
        send_text("fill:x\"");
    endtask

    task automatic test_id_and_path();
        send_text("id=\"a>\"");
        send_text("d=\"M1;\"");
    endtask

    task automatic test_stroke_width();
        send_text("stroke-width:1.2345.6x>;");
        send_text("stroke-width:2\"");
        send_char(CHAR_GT);
    endtask

    task automatic test_saturation();
        send_text("stroke-width:99999;>");
    endtask

    task automatic test_naive_restart();
        send_text("ffill:;iid=\"q\">");
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_requested = 1'b1;
        while (hold_requested)
            @(posedge i_clk);
        source_steady = 1'b1;
        send_tag(FILL_TAG, FILL_LEN, FILL_LEN);
        repeat (40) send_char(value_byte(1'b1));
        send_char(CHAR_SEMI);
        source_steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_text("d=\"L2");
        wait_drained();
        send_text("3\">");
    endtask

    task automatic send_width_value();
        int         int_digits;
        int         frac_digits;
        logic [7:0] junk;
        int_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 2);
        repeat (int_digits) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0) begin
            send_char(CHAR_DOT);
            frac_digits = $urandom_range(0, 5);
            for (int i = 0; i < frac_digits; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    junk = value_byte(1'b1);
                    send_char(junk);
                end
                send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        send_char($urandom_range(0, 1) ? CHAR_SEMI : CHAR_QUOTE);
    endtask

    task automatic send_broken_tag();
        case ($urandom_range(0, 3))
            0: send_tag(STROKE_TAG, STROKE_LEN, $urandom_range(1, STROKE_LEN - 1));
            1: send_tag(FILL_TAG, FILL_LEN, $urandom_range(1, FILL_LEN - 1));
            2: send_tag(ID_TAG, ID_LEN, $urandom_range(1, ID_LEN - 1));
            default: send_tag(PATH_TAG, PATH_LEN, $urandom_range(1, PATH_LEN - 1));
        endcase
        send_char(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_element();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_tag(STROKE_TAG, STROKE_LEN, STROKE_LEN);
                    send_width_value();
                end
                2, 3: begin
                    send_tag(FILL_TAG, FILL_LEN, FILL_LEN);
                    repeat ($urandom_range(0, 8)) send_char(value_byte(1'b1));
                    send_char($urandom_range(0, 1) ? CHAR_SEMI : CHAR_QUOTE);
                end
                4: begin
                    send_tag(ID_TAG, ID_LEN, ID_LEN);
                    repeat ($urandom_range(0, 8)) send_char(value_byte(1'b0));
                    send_char(CHAR_QUOTE);
                end
                5, 6: begin
                    send_tag(PATH_TAG, PATH_LEN, PATH_LEN);
                    repeat ($urandom_range(0, 12)) send_char(value_byte(1'b0));
                    send_char(CHAR_QUOTE);
                end
                7: send_broken_tag();
                8: repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
                default: send_char(CHAR_GT);
            endcase
        end
        if ($urandom_range(0, 7) != 0)
            send_char(CHAR_GT);
    endtask

    task automatic test_random_elements();
        int stop_at;
        stop_at = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_at) begin
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            send_random_element();
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    initial begin
        char_bus.valid   = 1'b0;
        char_bus.char_in = '0;
        reset_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_element_end();
        test_fill_value();
        test_id_and_path();
        test_stroke_width();
        test_saturation();
        test_naive_restart();
        test_backpressure();
        test_drain_pause();
        test_random_elements();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("svg_path_attribute_scanner_core regression: pass");
        else
            $display("svg_path_attribute_scanner_core regression: fail");
        $finish;
    end

endmodule
